// ===== hdl/cmdtok_pkg.sv =====
`timescale 1ns / 1ps

package cmdtok_pkg;

	localparam int TOK_W  = 8;
	localparam int CHAR_W = 8;
	localparam int BUF_W  = 13;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 13;
	localparam int MAX_RES = 3;
	localparam int RCNT_W = 2;

	localparam logic [TOK_W-1:0] MAX_TOKENS_RST  = 8'd80;
	localparam logic [BUF_W-1:0] BUFFER_SIZE_RST = 13'd2048;

	localparam logic CFG_MAX_TOKENS  = 1'b0;
	localparam logic CFG_BUFFER_SIZE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_TOO_MANY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;

	typedef enum logic [2:0] {
		MODE_BETWEEN,
		MODE_SLASH,
		MODE_BARE,
		MODE_QUOTED,
		MODE_STOPPED
	} mode_t;

	typedef struct packed {
		logic [TOK_W-1:0]  token_index;
		logic              token_start;
		logic              has_char;
		logic [CHAR_W-1:0] char_out;
		logic              token_end;
		logic              line_done;
		logic [TOK_W-1:0]  token_count;
		logic [STAT_W-1:0] status;
	} res_t;

	// Results caused by one item, slot 0 first
	typedef struct packed {
		logic [RCNT_W-1:0]        count;
		res_t [MAX_RES-1:0]       res;
	} bundle_t;

	function automatic res_t mk_res(
		input logic              start,
		input logic              hc,
		input logic [CHAR_W-1:0] ch,
		input logic              fin,
		input logic              done,
		input logic [TOK_W-1:0]  idx,
		input logic [TOK_W-1:0]  cnt,
		input logic [STAT_W-1:0] st
	);
		res_t r;
		r.token_index = idx;
		r.token_start = start;
		r.has_char    = hc;
		r.char_out    = hc ? ch : '0;
		r.token_end   = fin;
		r.line_done   = done;
		r.token_count = cnt;
		r.status      = st;
		return r;
	endfunction

	function automatic logic room(
		input logic [BUF_W-1:0] used,
		input logic [BUF_W-1:0] size
	);
		return ({1'b0, used} + {{BUF_W{1'b0}}, 1'b1}) < {1'b0, size};
	endfunction

endpackage

// ===== hdl/cmdtok_if.sv =====
`timescale 1ns / 1ps

interface cmdtok_char_if;
	logic                           valid;
	logic                           ready;
	logic [cmdtok_pkg::CHAR_W-1:0]  char_byte;
	logic                           last;

	modport source (output valid, output char_byte, output last, input ready);
	modport sink   (input valid, input char_byte, input last, output ready);
endinterface

interface cmdtok_res_if;
	logic                           valid;
	logic                           ready;
	logic [cmdtok_pkg::TOK_W-1:0]   token_index;
	logic                           token_start;
	logic                           has_char;
	logic [cmdtok_pkg::CHAR_W-1:0]  char_out;
	logic                           token_end;
	logic                           line_done;
	logic [cmdtok_pkg::TOK_W-1:0]   token_count;
	logic [cmdtok_pkg::STAT_W-1:0]  status;
	logic                           last_result;

	modport source (
		output valid, output token_index, output token_start, output has_char,
		output char_out, output token_end, output line_done, output token_count,
		output status, output last_result, input ready
	);
	modport sink (
		input valid, input token_index, input token_start, input has_char,
		input char_out, input token_end, input line_done, input token_count,
		input status, input last_result, output ready
	);
endinterface

// ===== hdl/command_line_tokenizer.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// chars     in   valid/ready        char_byte, last
// tokens    out  valid/ready        token_index .. status, last_result
// cfg       in   cfg_we, no ready   cfg_index, cfg_data
//
// A byte is decoded in the cycle it is taken; its results (zero to three) sit in
// the result register and leave one per cycle while the output is ready. A new
// byte is taken in the cycle the last held result is taken. Reset clears the
// scan state and loads the register defaults.
// A stalled output holds the current result and blocks further bytes.

module command_line_tokenizer (
	input  logic                          clk,
	input  logic                          arst_n,
	cmdtok_char_if.sink                   chars,
	cmdtok_res_if.source                  tokens,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [cmdtok_pkg::CFG_W-1:0]  cfg_data
);

	logic                 load_ok;
	logic                 push;
	cmdtok_pkg::bundle_t  bundle;

	cmdtok_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.load_ok   (load_ok),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.bundle    (bundle)
	);

	cmdtok_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.bundle  (bundle),
		.load_ok (load_ok),
		.tokens  (tokens)
	);

endmodule

// ===== hdl/cmdtok_core.sv =====
`timescale 1ns / 1ps

module cmdtok_core (
	input  logic                              clk,
	input  logic                              arst_n,
	cmdtok_char_if.sink                       chars,
	input  logic                              load_ok,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [cmdtok_pkg::CFG_W-1:0]      cfg_data,
	output logic                              push,
	output cmdtok_pkg::bundle_t               bundle
);

	logic                               accept;
	logic [cmdtok_pkg::TOK_W-1:0]       max_tokens_q;
	logic [cmdtok_pkg::BUF_W-1:0]       buffer_size_q;
	cmdtok_pkg::mode_t                  mode_q;
	logic [cmdtok_pkg::TOK_W-1:0]       tokens_q;
	logic [cmdtok_pkg::BUF_W-1:0]       bytes_q;
	logic [cmdtok_pkg::STAT_W-1:0]      fail_q;

	cmdtok_pkg::mode_t                  mode_c;
	cmdtok_pkg::mode_t                  open_next_c;
	cmdtok_pkg::mode_t                  close_next_c;
	logic [cmdtok_pkg::TOK_W-1:0]       tokens_c;
	logic [cmdtok_pkg::BUF_W-1:0]       bytes_c;
	logic [cmdtok_pkg::STAT_W-1:0]      fail_c;
	logic [cmdtok_pkg::RCNT_W-1:0]      n_c;
	cmdtok_pkg::res_t [cmdtok_pkg::MAX_RES-1:0] res_c;
	logic                               open_req_c;
	logic                               open_has_c;
	logic [cmdtok_pkg::CHAR_W-1:0]      open_first_c;
	logic                               bare_c;
	logic                               put_req_c;
	logic                               close_req_c;
	logic [cmdtok_pkg::CHAR_W-1:0]      c;
	logic                               is_ws;
	logic                               is_stop;

	assign chars.ready = load_ok;
	assign accept      = chars.valid && load_ok;
	assign c           = chars.char_byte;
	assign is_ws       = (c == cmdtok_pkg::CH_SPACE) || (c == cmdtok_pkg::CH_TAB);
	assign is_stop     = (c == cmdtok_pkg::CH_NUL) || (c == cmdtok_pkg::CH_SEMI) ||
	                     (c == cmdtok_pkg::CH_LF);

	always_comb begin
		mode_c       = mode_q;
		tokens_c     = tokens_q;
		bytes_c      = bytes_q;
		fail_c       = fail_q;
		n_c          = '0;
		res_c        = '0;
		open_req_c   = 1'b0;
		open_has_c   = 1'b0;
		open_first_c = '0;
		open_next_c  = cmdtok_pkg::MODE_BARE;
		close_next_c = cmdtok_pkg::MODE_BETWEEN;
		bare_c       = 1'b0;
		put_req_c    = 1'b0;
		close_req_c  = 1'b0;

		// decide what this byte does
		case (mode_q)
			cmdtok_pkg::MODE_BETWEEN: begin
				if (is_ws) begin
					mode_c = cmdtok_pkg::MODE_BETWEEN;
				end else if (is_stop) begin
					mode_c = cmdtok_pkg::MODE_STOPPED;
				end else if (c == cmdtok_pkg::CH_SLASH) begin
					if (chars.last) begin
						// line ends on a pending slash: open it as a bare token
						open_req_c   = 1'b1;
						open_has_c   = 1'b1;
						open_first_c = cmdtok_pkg::CH_SLASH;
					end else begin
						mode_c = cmdtok_pkg::MODE_SLASH;
					end
				end else if (c == cmdtok_pkg::CH_QUOTE) begin
					open_req_c  = 1'b1;
					open_next_c = cmdtok_pkg::MODE_QUOTED;
				end else begin
					open_req_c   = 1'b1;
					open_has_c   = 1'b1;
					open_first_c = c;
				end
			end
			cmdtok_pkg::MODE_SLASH: begin
				if (c == cmdtok_pkg::CH_SLASH) begin
					mode_c = cmdtok_pkg::MODE_STOPPED;
				end else begin
					open_req_c   = 1'b1;
					open_has_c   = 1'b1;
					open_first_c = cmdtok_pkg::CH_SLASH;
					bare_c       = 1'b1;
				end
			end
			cmdtok_pkg::MODE_BARE: begin
				bare_c = 1'b1;
			end
			cmdtok_pkg::MODE_QUOTED: begin
				if (c == cmdtok_pkg::CH_NUL) begin
					close_req_c  = 1'b1;
					close_next_c = cmdtok_pkg::MODE_STOPPED;
				end else if (c == cmdtok_pkg::CH_QUOTE) begin
					close_req_c  = 1'b1;
					close_next_c = cmdtok_pkg::MODE_BETWEEN;
				end else begin
					put_req_c = 1'b1;
				end
			end
			default: begin
				mode_c = mode_q;
			end
		endcase

		// open a token, or fail the line
		if (open_req_c) begin
			if (tokens_c >= max_tokens_q) begin
				fail_c = cmdtok_pkg::ST_TOO_MANY;
				mode_c = cmdtok_pkg::MODE_STOPPED;
				bare_c = 1'b0;
			end else if (!cmdtok_pkg::room(bytes_c, buffer_size_q)) begin
				fail_c = cmdtok_pkg::ST_FULL;
				mode_c = cmdtok_pkg::MODE_STOPPED;
				bare_c = 1'b0;
			end else begin
				tokens_c = tokens_c + 8'd1;
				if (open_has_c) begin
					bytes_c = bytes_c + 13'd1;
				end
				mode_c   = open_next_c;
				res_c[n_c] = cmdtok_pkg::mk_res(1'b1, open_has_c, open_first_c, 1'b0,
					1'b0, tokens_c - 8'd1, tokens_c, fail_c);
				n_c = n_c + 2'd1;
			end
		end

		if (bare_c) begin
			if (is_stop) begin
				close_req_c  = 1'b1;
				close_next_c = cmdtok_pkg::MODE_STOPPED;
			end else if (is_ws) begin
				close_req_c  = 1'b1;
				close_next_c = cmdtok_pkg::MODE_BETWEEN;
			end else begin
				put_req_c = 1'b1;
			end
		end

		// drop the character silently when the buffer is full
		if (put_req_c && cmdtok_pkg::room(bytes_c, buffer_size_q)) begin
			bytes_c = bytes_c + 13'd1;
			res_c[n_c] = cmdtok_pkg::mk_res(1'b0, 1'b1, c, 1'b0, 1'b0,
				tokens_c - 8'd1, tokens_c, fail_c);
			n_c = n_c + 2'd1;
		end

		if (close_req_c) begin
			bytes_c = bytes_c + 13'd1;
			mode_c  = close_next_c;
			res_c[n_c] = cmdtok_pkg::mk_res(1'b0, 1'b0, '0, 1'b1, 1'b0,
				tokens_c - 8'd1, tokens_c, fail_c);
			n_c = n_c + 2'd1;
		end

		if (chars.last) begin
			if (mode_c == cmdtok_pkg::MODE_BARE || mode_c == cmdtok_pkg::MODE_QUOTED) begin
				res_c[n_c] = cmdtok_pkg::mk_res(1'b0, 1'b0, '0, 1'b1, 1'b1,
					tokens_c - 8'd1, tokens_c, fail_c);
			end else begin
				res_c[n_c] = cmdtok_pkg::mk_res(1'b0, 1'b0, '0, 1'b0, 1'b1,
					'0, tokens_c, fail_c);
			end
			n_c      = n_c + 2'd1;
			mode_c   = cmdtok_pkg::MODE_BETWEEN;
			tokens_c = '0;
			bytes_c  = '0;
			fail_c   = cmdtok_pkg::ST_OK;
		end
	end

	assign push         = accept && (n_c != '0);
	assign bundle.count = n_c;
	assign bundle.res   = res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q  <= cmdtok_pkg::MAX_TOKENS_RST;
			buffer_size_q <= cmdtok_pkg::BUFFER_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cmdtok_pkg::CFG_MAX_TOKENS:  max_tokens_q  <= cfg_data[cmdtok_pkg::TOK_W-1:0];
				cmdtok_pkg::CFG_BUFFER_SIZE: buffer_size_q <= cfg_data[cmdtok_pkg::BUF_W-1:0];
				default: max_tokens_q <= max_tokens_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= cmdtok_pkg::MODE_BETWEEN;
			tokens_q <= '0;
			bytes_q  <= '0;
			fail_q   <= cmdtok_pkg::ST_OK;
		end else if (accept) begin
			mode_q   <= mode_c;
			tokens_q <= tokens_c;
			bytes_q  <= bytes_c;
			fail_q   <= fail_c;
		end
	end

endmodule

// ===== hdl/cmdtok_out.sv =====
`timescale 1ns / 1ps

module cmdtok_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cmdtok_pkg::bundle_t  bundle,
	output logic                 load_ok,
	cmdtok_res_if.source         tokens
);

	logic                                      valid_q;
	logic [cmdtok_pkg::RCNT_W-1:0]             cnt_s1;
	cmdtok_pkg::res_t [cmdtok_pkg::MAX_RES-1:0] res_s1;
	logic [cmdtok_pkg::RCNT_W-1:0]             ptr_q;
	logic                                      is_last;
	logic                                      take;
	cmdtok_pkg::res_t                          cur;

	assign cur     = res_s1[ptr_q];
	assign is_last = (ptr_q == cnt_s1 - 2'd1);
	assign take    = valid_q && tokens.ready;
	// the held bundle frees up as its final result is taken
	assign load_ok = !valid_q || (take && is_last);

	assign tokens.valid       = valid_q;
	assign tokens.token_index = cur.token_index;
	assign tokens.token_start = cur.token_start;
	assign tokens.has_char    = cur.has_char;
	assign tokens.char_out    = cur.char_out;
	assign tokens.token_end   = cur.token_end;
	assign tokens.line_done   = cur.line_done;
	assign tokens.token_count = cur.token_count;
	assign tokens.status      = cur.status;
	assign tokens.last_result = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ptr_q   <= '0;
		end else if (push) begin
			valid_q <= 1'b1;
			ptr_q   <= '0;
		end else if (take) begin
			if (is_last) begin
				valid_q <= 1'b0;
				ptr_q   <= '0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cnt_s1 <= bundle.count;
			res_s1 <= bundle.res;
		end
	end

endmodule
